>>> hdl/bea_pkg.sv
// shared types and constants for the button edge and auto-repeat block
`default_nettype none

package bea_pkg;

  localparam int unsigned PAD_FIELD_W   = 3;
  localparam int unsigned BTN_FIELD_W   = 16;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned IN_TUSER_W    = 4;
  localparam int unsigned OUT_TDATA_W   = 56;
  localparam int unsigned CFG_ADDR_W    = 4;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_BYTE_W    = 8;

  localparam logic [7:0]  WAIT_RESET   = 8'd20;
  localparam logic [7:0]  PERIOD_RESET = 8'd5;
  localparam logic [15:0] MASK_RESET   = 16'h0FFF;

  typedef enum logic [1:0] {
    REG_INITIAL_DELAY = 2'd0,
    REG_REPEAT_PERIOD = 2'd1,
    REG_REPEAT_MASK   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_BYTE_W-1:0]  initial_delay;
    logic [CFG_BYTE_W-1:0]  repeat_period;
    logic [BTN_FIELD_W-1:0] repeat_mask;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/button_edge_and_autorepeat_top.sv
// top level: pad history, config registers, button lanes and output stage
//
//   channel  | dir | beat contents
//   s_*      | in  | tdata: buttons; tuser: pad_index, inactive
//   m_*      | out | tdata: held, pressed, repeat_pulse, active_pad
//   apb      | in  | initial_delay, repeat_period, repeat_mask at 0x0, 0x4, 0x8
//
// one beat per cycle; a beat is read, updated and written back in the cycle it is taken
// the result appears on m_* the cycle after the input beat
// s_tready drops only while a result is held and m_tready is low
// rst is synchronous; all pad history and counters clear at once
`default_nettype none

module button_edge_and_autorepeat_top
  import bea_pkg::*;
#(
  parameter int unsigned NUM_PADS    = 8,
  parameter int unsigned NUM_BUTTONS = 16,
  parameter int unsigned COUNT_BITS  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // buttons[15:0]
  input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // pad_index[2:0], inactive[3]
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,   // held, pressed, repeat_pulse, active_pad
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  paddr,
  input  wire logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]       prdata,
  output logic                        pready
);

  localparam int unsigned PAD_IW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int unsigned CMP_W  = 6;

  cfg_t cfg;

  logic [NUM_BUTTONS-1:0] cur_mem   [NUM_PADS];
  logic [NUM_BUTTONS-1:0] prev_mem  [NUM_PADS];
  logic [NUM_BUTTONS-1:0] rep_mem   [NUM_PADS];
  logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0] cnt_mem [NUM_PADS];

  logic                   accept;
  logic                   in_range;
  logic                   inactive;
  logic [PAD_FIELD_W-1:0] pad;
  logic [PAD_IW-1:0]      idx;
  logic [NUM_BUTTONS-1:0] raw;
  logic [NUM_BUTTONS-1:0] cur_old;
  logic [NUM_BUTTONS-1:0] prev_old;
  logic [NUM_BUTTONS-1:0] rep_old;
  logic [NUM_BUTTONS-1:0] cur_new;
  logic [NUM_BUTTONS-1:0] pressed;
  logic [NUM_BUTTONS-1:0] rep_new;
  logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0] cnt_old;
  logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0] cnt_new;
  logic [NUM_BUTTONS-1:0] held_out;
  logic [NUM_BUTTONS-1:0] pressed_out;
  logic [NUM_BUTTONS-1:0] rep_out;
  logic                   lane_en;
  logic                   in_ready;
  logic                   cfg_write;
  reg_idx_t               reg_sel;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay <= WAIT_RESET;
      cfg.repeat_period <= PERIOD_RESET;
      cfg.repeat_mask   <= MASK_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_INITIAL_DELAY: cfg.initial_delay <= pwdata[CFG_BYTE_W-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period <= pwdata[CFG_BYTE_W-1:0];
        REG_REPEAT_MASK:   cfg.repeat_mask   <= pwdata[BTN_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INITIAL_DELAY: prdata = CFG_DATA_W'(cfg.initial_delay);
      REG_REPEAT_PERIOD: prdata = CFG_DATA_W'(cfg.repeat_period);
      REG_REPEAT_MASK:   prdata = CFG_DATA_W'(cfg.repeat_mask);
      default:           prdata = '0;
    endcase
  end

  // input decode and per-pad read
  assign s_tready = in_ready;
  assign accept   = s_tvalid && s_tready;
  assign pad      = s_tuser[PAD_FIELD_W-1:0];
  assign inactive = s_tuser[PAD_FIELD_W];
  assign in_range = CMP_W'(pad) < CMP_W'(NUM_PADS);
  assign idx      = PAD_IW'(CMP_W'(pad));

  assign cur_old  = cur_mem[idx];
  assign prev_old = prev_mem[idx];
  assign rep_old  = rep_mem[idx];
  assign cnt_old  = cnt_mem[idx];

  assign cur_new  = inactive ? cur_old : raw;
  assign pressed  = cur_new & ~(cur_old | prev_old);
  assign lane_en  = in_range && !inactive;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    logic mask_bit;
    if (b < BTN_FIELD_W) begin : g_in
      assign raw[b]   = s_tdata[b];
      assign mask_bit = cfg.repeat_mask[b];
    end else begin : g_pad
      assign raw[b]   = 1'b0;
      assign mask_bit = 1'b0;
    end

    bea_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .en       (lane_en && mask_bit),
      .cfg      (cfg),
      .cur      (cur_new[b]),
      .pressed  (pressed[b]),
      .rep_old  (rep_old[b]),
      .cnt      (cnt_old[b]),
      .cnt_next (cnt_new[b]),
      .rep_next (rep_new[b])
    );
  end

  // per-pad write back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        cur_mem[p]   <= '0;
        prev_mem[p]  <= '0;
        rep_mem[p]   <= '0;
        cnt_mem[p]   <= '0;
      end
    end else if (accept && in_range) begin
      prev_mem[idx]  <= cur_old;
      cur_mem[idx]   <= cur_new;
      rep_mem[idx]   <= rep_new;
      cnt_mem[idx]   <= cnt_new;
    end
  end

  assign held_out    = in_range ? cur_new : '0;
  assign pressed_out = in_range ? pressed : '0;
  assign rep_out     = in_range ? rep_new : '0;

  bea_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .update_active (lane_en),
    .pad           (pad),
    .held_word     (held_out),
    .pressed_word  (pressed_out),
    .rep_word      (rep_out),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata),
    .in_ready      (in_ready)
  );

endmodule

`default_nettype wire

>>> hdl/bea_lane.sv
// one button lane: typematic down-counter and repeat bit
`default_nettype none

module bea_lane
  import bea_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 8
) (
  input  wire logic                  en,
  input  wire cfg_t                  cfg,
  input  wire logic                  cur,
  input  wire logic                  pressed,
  input  wire logic                  rep_old,
  input  wire logic [COUNT_BITS-1:0] cnt,
  output logic [COUNT_BITS-1:0]      cnt_next,
  output logic                       rep_next
);

  always_comb begin
    cnt_next = cnt;
    rep_next = rep_old;
    if (en) begin
      if (cur) begin
        if (cnt == '0) begin
          cnt_next = COUNT_BITS'(cfg.repeat_period);
          rep_next = 1'b1;
        end else begin
          cnt_next = cnt - COUNT_BITS'(1);
          rep_next = 1'b0;
        end
      end else begin
        cnt_next = COUNT_BITS'(cfg.initial_delay);
        rep_next = 1'b0;
      end
      if (pressed) begin
        rep_next = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/bea_merge.sv
// merges lane words, tracks the last active pad and holds the output beat
`default_nettype none

module bea_merge
  import bea_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic                   update_active,
  input  wire logic [PAD_FIELD_W-1:0] pad,
  input  wire logic [NUM_BUTTONS-1:0] held_word,
  input  wire logic [NUM_BUTTONS-1:0] pressed_word,
  input  wire logic [NUM_BUTTONS-1:0] rep_word,
  input  wire logic                   m_tready,
  output logic                        m_tvalid,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        in_ready
);

  logic [PAD_FIELD_W-1:0] last_active;
  logic [PAD_FIELD_W-1:0] last_active_next;
  logic [BTN_FIELD_W-1:0] held16;
  logic [BTN_FIELD_W-1:0] pressed16;
  logic [BTN_FIELD_W-1:0] rep16;

  for (genvar i = 0; i < BTN_FIELD_W; i++) begin : g_bit
    if (i < NUM_BUTTONS) begin : g_on
      assign held16[i]    = held_word[i];
      assign pressed16[i] = pressed_word[i];
      assign rep16[i]     = rep_word[i];
    end else begin : g_off
      assign held16[i]    = 1'b0;
      assign pressed16[i] = 1'b0;
      assign rep16[i]     = 1'b0;
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  always_comb begin
    last_active_next = last_active;
    if (update_active && (held_word != '0)) begin
      last_active_next = pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      last_active <= '0;
    end else begin
      if (accept) begin
        m_tvalid    <= 1'b1;
        last_active <= last_active_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {(OUT_TDATA_W - PAD_FIELD_W - 3 * BTN_FIELD_W)'(0),
                  last_active_next, rep16, pressed16, held16};
    end
  end

endmodule

`default_nettype wire

>>> bench/button_edge_and_autorepeat_top_tb.sv
// self-checking testbench for the button edge and auto-repeat block
`timescale 1ns / 100ps

module button_edge_and_autorepeat_top_tb;
  import bea_pkg::*;

  localparam int unsigned PADS       = 8;
  localparam int unsigned BUTTONS    = 16;
  localparam int unsigned STUCK_MAX  = 4000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 229;
  localparam int unsigned SHOW_MAX   = 40;

  typedef struct packed {
    logic [4:0]  fill;
    logic [2:0]  active_pad;
    logic [15:0] repeat_pulse;
    logic [15:0] pressed;
    logic [15:0] held;
  } report_t;

  class typematic_scoreboard;
    bit [7:0]  wait_load;
    bit [7:0]  period_load;
    bit [15:0] repeat_sel;
    bit [15:0] word_now [PADS];
    bit [15:0] word_prev [PADS];
    bit [15:0] word_older [PADS];
    bit [15:0] pulse_word [PADS];
    bit [7:0]  down_count [PADS][BUTTONS];
    bit [2:0]  last_pad;
    report_t   expected_reports [$];
    int        errors;

    function new();
      wait_load   = WAIT_RESET;
      period_load = PERIOD_RESET;
      repeat_sel  = MASK_RESET;
      last_pad    = '0;
      errors      = 0;
      for (int p = 0; p < PADS; p++) begin
        word_now[p]   = '0;
        word_prev[p]  = '0;
        word_older[p] = '0;
        pulse_word[p] = '0;
        for (int b = 0; b < BUTTONS; b++) down_count[p][b] = '0;
      end
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_INITIAL_DELAY: wait_load   = value[7:0];
        REG_REPEAT_PERIOD: period_load = value[7:0];
        REG_REPEAT_MASK:   repeat_sel  = value[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(reg_idx_t idx);
      case (idx)
        REG_INITIAL_DELAY: return {24'd0, wait_load};
        REG_REPEAT_PERIOD: return {24'd0, period_load};
        REG_REPEAT_MASK:   return {16'd0, repeat_sel};
        default:           return '0;
      endcase
    endfunction

    function void note_frame(bit [2:0] pad, bit [15:0] buttons, bit inactive);
      report_t   r;
      bit [15:0] edges;
      bit [15:0] rep;
      word_older[pad] = word_prev[pad];
      word_prev[pad]  = word_now[pad];
      if (!inactive) word_now[pad] = buttons;
      edges = word_now[pad] & ~(word_prev[pad] | word_older[pad]);
      if (!inactive) begin
        if (word_now[pad] != 0) last_pad = pad;
        rep = pulse_word[pad];
        for (int b = 0; b < BUTTONS; b++) begin
          if (repeat_sel[b]) begin
            if (word_now[pad][b]) begin
              if (down_count[pad][b] == 0) begin
                down_count[pad][b] = period_load;
                rep[b] = 1'b1;
              end else begin
                down_count[pad][b] = down_count[pad][b] - 1'b1;
                rep[b] = 1'b0;
              end
            end else begin
              down_count[pad][b] = wait_load;
              rep[b] = 1'b0;
            end
            if (edges[b]) rep[b] = 1'b1;
          end
        end
        pulse_word[pad] = rep;
      end
      r = '0;
      r.held         = word_now[pad];
      r.pressed      = edges;
      r.repeat_pulse = pulse_word[pad];
      r.active_pad   = last_pad;
      expected_reports.push_back(r);
    endfunction

    function void flag(string what, logic [15:0] exp_v, logic [15:0] got_v);
      errors++;
      if (errors <= SHOW_MAX)
        $display("%0t mismatch %s: expected %h actual %h", $realtime, what, exp_v, got_v);
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t unexpected beat: expected none actual %h", $realtime, got);
        return;
      end
      exp_r = expected_reports.pop_front();
      if (got.held !== exp_r.held) flag("held", exp_r.held, got.held);
      if (got.pressed !== exp_r.pressed) flag("pressed", exp_r.pressed, got.pressed);
      if (got.repeat_pulse !== exp_r.repeat_pulse)
        flag("repeat_pulse", exp_r.repeat_pulse, got.repeat_pulse);
      if (got.active_pad !== exp_r.active_pad)
        flag("active_pad", {13'd0, exp_r.active_pad}, {13'd0, got.active_pad});
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // buttons[15:0]
  logic [IN_TUSER_W-1:0]  s_tuser;   // pad_index[2:0], inactive[3]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // held[15:0], pressed[31:16], repeat_pulse[47:32],
                                     // active_pad[50:48]
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [CFG_DATA_W-1:0]  pwdata;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  typematic_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned stuck_cycles;

  button_edge_and_autorepeat_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_frame(s_tuser[2:0], s_tdata, s_tuser[3]);
      if (m_tvalid && m_tready) sb.check_report(report_t'(m_tdata));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_MAX) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_frame(input logic [2:0] pad, input logic [15:0] buttons,
                            input logic inactive);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= buttons;
    s_tuser  <= {inactive, pad};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] exp_v;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    exp_v = sb.register_value(idx);
    if (prdata !== exp_v) begin
      sb.errors++;
      $display("%0t mismatch read %s: expected %h actual %h", $realtime, idx.name(),
               exp_v, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    logic [2:0]  focus_pad;
    logic [15:0] focus_word;
    int          burst_left;
    int unsigned roll;

    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    m_tready       = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stuck_cycles   = 0;
    burst_left     = 0;
    focus_pad      = '0;
    focus_word     = '0;
    sb = new();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: edges, holds, re-press gaps, inactive frames, pad extremes
    send_frame(3'd0, 16'hFFFF, 1'b0);
    send_frame(3'd0, 16'hFFFF, 1'b0);
    send_frame(3'd0, 16'h0000, 1'b0);
    send_frame(3'd0, 16'hFFFF, 1'b0);
    send_frame(3'd0, 16'h0000, 1'b0);
    send_frame(3'd0, 16'h0000, 1'b0);
    send_frame(3'd0, 16'hF00F, 1'b0);
    send_frame(3'd7, 16'h8001, 1'b0);
    send_frame(3'd7, 16'h5555, 1'b1);
    send_frame(3'd7, 16'hAAAA, 1'b0);
    send_frame(3'd7, 16'h0000, 1'b1);
    send_frame(3'd7, 16'h0000, 1'b0);
    send_frame(3'd3, 16'h0000, 1'b0);
    send_frame(3'd5, 16'h0001, 1'b1);
    send_frame(3'd5, 16'h8000, 1'b0);
    for (int i = 0; i < 8; i++) send_frame(3'd2, 16'h1000, 1'b0);
    send_frame(3'd6, 16'h0000, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          write_register(REG_INITIAL_DELAY, 32'd0);
          write_register(REG_REPEAT_PERIOD, 32'd0);
          write_register(REG_REPEAT_MASK, 32'hFFFF);
        end
        1: begin
          write_register(REG_INITIAL_DELAY, 32'd255);
          write_register(REG_REPEAT_PERIOD, 32'd255);
          write_register(REG_REPEAT_MASK, 32'h0000);
        end
        2: begin
          write_register(REG_INITIAL_DELAY, 32'd2);
          write_register(REG_REPEAT_PERIOD, 32'd1);
          write_register(REG_REPEAT_MASK, {16'd0, 16'($urandom)});
        end
        3: begin
          write_register(REG_INITIAL_DELAY, 32'd255);
          write_register(REG_REPEAT_PERIOD, 32'd0);
          write_register(REG_REPEAT_MASK, 32'hFFFF);
        end
        4: begin
          write_register(REG_INITIAL_DELAY, 32'd0);
          write_register(REG_REPEAT_PERIOD, 32'd255);
          write_register(REG_REPEAT_MASK, 32'hAAAA);
        end
        5: begin
          write_register(REG_INITIAL_DELAY, $urandom_range(0, 8));
          write_register(REG_REPEAT_PERIOD, $urandom_range(0, 4));
          write_register(REG_REPEAT_MASK, {16'd0, 16'($urandom)});
        end
        6: begin
          write_register(REG_INITIAL_DELAY, $urandom_range(0, 255));
          write_register(REG_REPEAT_PERIOD, $urandom_range(0, 255));
          write_register(REG_REPEAT_MASK, 32'h5555);
        end
        default: begin
          write_register(REG_INITIAL_DELAY, $urandom_range(0, 3));
          write_register(REG_REPEAT_PERIOD, $urandom_range(0, 3));
          write_register(REG_REPEAT_MASK, {16'd0, 16'($urandom)});
        end
      endcase

      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase

      // mostly held words on one pad at a time so the repeat counters run out
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (burst_left == 0) begin
          focus_pad  = $urandom_range(0, PADS - 1);
          focus_word = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                   : 16'($urandom & $urandom & $urandom);
          burst_left = $urandom_range(5, 40);
        end
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          if ($urandom_range(0, 9) == 0) focus_word[$urandom_range(0, BUTTONS - 1)] ^= 1'b1;
          if ($urandom_range(0, 24) == 0) focus_word = '0;
          send_frame(focus_pad, focus_word, 1'b0);
        end else if (roll < 88) begin
          send_frame(focus_pad, 16'($urandom), 1'b1);
        end else begin
          send_frame(3'($urandom_range(0, PADS - 1)), 16'($urandom), 1'($urandom_range(0, 1)));
        end
        burst_left--;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bea_pkg.sv
hdl/bea_lane.sv
hdl/bea_merge.sv
hdl/button_edge_and_autorepeat_top.sv
bench/button_edge_and_autorepeat_top_tb.sv
